// ===== hw/rtl/mqr_pkg.sv =====
// Package for the message queue with indexed removal.
// Holds the queue sizes, the operation and status codes and the transaction structs.
// Depends on nothing; imported by the queue top level.
package mqr_pkg;

   localparam int DEPTH       = 16;
   localparam int MSG_WIDTH   = 32;
   localparam int SLOT_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS  = $clog2(DEPTH + 1);
   localparam int CAP_BITS    = 5;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      op_type                 func;
      logic [MSG_WIDTH-1:0]   message;
      logic [SLOT_BITS-1:0]   position;
   } req_type;

   typedef struct packed {
      logic [MSG_WIDTH-1:0]   out_message;
      status_type             status;
      logic [COUNT_BITS-1:0]  count;
   } rsp_type;

endpackage

// ===== hw/rtl/message_queue_with_indexed_removal.sv =====
// A transaction is registered into req_ff, then its result and strobe into rsp_ff.
// Throughput: one transaction per cycle; busy is always low and the receiver cannot stall.
// The queue is a row of registers with the head in slot 0, closed up on every removal.
// Reset (synchronous, active high) empties the queue and sets the capacity register to 16.
// Slot contents are not reset; only slots below the count are ever read.
// Depends on mqr_pkg for sizes, codes and the transaction structs.
module message_queue_with_indexed_removal (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  mqr_pkg::req_type                req_data,
   output logic                            rsp_strobe,
   output mqr_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mqr_pkg::CAP_BITS-1:0]    csr_data
);
   import mqr_pkg::*;

   logic                     req_valid_ff;
   req_type                  req_ff;
   logic [COUNT_BITS-1:0]    count_ff;
   logic [COUNT_BITS-1:0]    count_in;
   logic [CAP_BITS-1:0]      cap_ff;
   logic [MSG_WIDTH-1:0]     entries_ff [DEPTH];
   logic                     rsp_strobe_ff;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   logic                     full;
   logic                     push_en;
   logic                     take_en;
   logic [SLOT_BITS-1:0]     slot;

   assign busy       = 1'b0;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign full = (COUNT_BITS'(count_ff) >= COUNT_BITS'(cap_ff))
              || (count_ff == COUNT_BITS'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      req_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   always_comb begin
      count_in           = count_ff;
      push_en            = 1'b0;
      take_en            = 1'b0;
      slot               = '0;
      rsp_in.out_message = '0;
      rsp_in.status      = ST_OK;
      unique case (req_ff.func)
         OP_PUSH: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               push_en  = req_valid_ff;
               count_in = count_ff + COUNT_BITS'(1);
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               take_en = req_valid_ff;
            end
         end
         OP_REMOVE: begin
            if (count_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else if (COUNT_BITS'(req_ff.position) >= count_ff) begin
               rsp_in.status = ST_RANGE;
            end else begin
               take_en = req_valid_ff;
               slot    = req_ff.position;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      if (rsp_in.status != ST_OK || req_ff.func == OP_PUSH || req_ff.func == OP_CLEAR) begin
         rsp_in.out_message = '0;
      end else begin
         rsp_in.out_message = entries_ff[slot];
         count_in           = count_ff - COUNT_BITS'(1);
      end
      rsp_in.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         entries_ff[count_ff[SLOT_BITS-1:0]] <= req_ff.message;
      end
      if (take_en) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (SLOT_BITS'(i) >= slot) begin
               entries_ff[i] <= entries_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
         if (req_valid_ff) begin
            count_ff <= count_in;
         end
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_idle : assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |=> $stable(count_ff))
      else $error("count changed without a transaction");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> count_ff <= COUNT_BITS'(DEPTH))
      else $error("count exceeds queue depth");

   a_refused_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.status != ST_OK |-> rsp_ff.out_message == '0)
      else $error("refused transaction returned a message");

   a_empty_count : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.status == ST_EMPTY |-> rsp_ff.count == '0)
      else $error("empty status with messages held");

   a_full_count : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.status == ST_FULL
      |-> (rsp_ff.count == COUNT_BITS'(DEPTH)) || (rsp_ff.count >= COUNT_BITS'(cap_ff)))
      else $error("full status below capacity");
`endif

endmodule
